FILE: hdl/tmp_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid motion profile package
// Shared widths, datapath operation codes, phase codes, register indexes and
// the status bundle passed from the datapath to the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmp_pkg;

   localparam int VALUE_WIDTH  = 32;
   localparam int DT_WIDTH     = 24;
   localparam int DT_FRAC_BITS = 24;
   localparam int PROD_WIDTH   = 2 * VALUE_WIDTH;
   localparam int CSR_IDX_W    = 2;

   typedef logic [4:0] op_type;

   // datapath operation codes
   localparam op_type OP_NOP        = 5'd0;
   localparam op_type OP_CAPTURE    = 5'd1;
   localparam op_type OP_REJECT     = 5'd2;
   localparam op_type OP_CHECK      = 5'd3;
   localparam op_type OP_SQ         = 5'd4;
   localparam op_type OP_DIVINIT_UP = 5'd5;
   localparam op_type OP_DIVINIT_DN = 5'd6;
   localparam op_type OP_DIVINIT_H  = 5'd7;
   localparam op_type OP_DIV_STEP   = 5'd8;
   localparam op_type OP_STORE_UP   = 5'd9;
   localparam op_type OP_STORE_DN   = 5'd10;
   localparam op_type OP_STORE_H    = 5'd11;
   localparam op_type OP_AD         = 5'd12;
   localparam op_type OP_SH         = 5'd13;
   localparam op_type OP_SQRT_INIT  = 5'd14;
   localparam op_type OP_SQRT_STEP  = 5'd15;
   localparam op_type OP_PEAK       = 5'd16;
   localparam op_type OP_BEGIN      = 5'd17;
   localparam op_type OP_FINISH     = 5'd18;
   localparam op_type OP_MUL_VDT    = 5'd19;
   localparam op_type OP_MUL_ADT    = 5'd20;
   localparam op_type OP_MUL_DDT    = 5'd21;
   localparam op_type OP_MUL_PDT    = 5'd22;
   localparam op_type OP_MUL_LOSS   = 5'd23;
   localparam op_type OP_ACCEL_UPD  = 5'd24;
   localparam op_type OP_DECEL_UPD  = 5'd25;
   localparam op_type OP_CRUISE_UPD = 5'd26;
   localparam op_type OP_EMIT       = 5'd27;

   // profile phase codes
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_ACCEL  = 2'd1;
   localparam logic [1:0] PH_CRUISE = 2'd2;
   localparam logic [1:0] PH_DECEL  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VLIM   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET = 2'd3;

   typedef struct packed {
      logic act;          // captured transaction is a start
      logic lim_bad;      // some limit register is zero
      logic tick_skip;    // idle or zero time step
      logic tick_finish;  // at target with zero velocity
      logic in_accel;     // position below ramp-up distance
      logic in_decel;     // position at or past deceleration start
      logic too_long;     // ramps exceed the move distance
      logic out_free;     // result register can take a new result
   } stat_type;

endpackage

`default_nettype wire

FILE: hdl/trapezoid_motion_profile_unit.sv
// ----------------------------------------------------------------------------
// Trapezoid motion profile unit
// Tick or rejected start: capture, dispatch, any update steps, then emit.
// Start transaction: its length is set by the one-bit-per-cycle divider (64
// steps, run twice, or five times when the peak is lowered) and the 32-step
// square root. One transaction is in work at a time; the next is accepted
// the cycle after the result is loaded.
// Synchronous reset clears the limits, profile state and result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trapezoid_motion_profile_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_action,
   input  wire logic [tmp_pkg::DT_WIDTH-1:0]       req_time_step,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [tmp_pkg::VALUE_WIDTH-1:0]         rsp_position,
   output logic [tmp_pkg::VALUE_WIDTH-1:0]         rsp_velocity,
   output logic                                    rsp_moving,
   output logic [1:0]                              rsp_phase,
   output logic                                    rsp_status,
   input  wire logic                               csr_write_enable,
   input  wire logic [tmp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tmp_pkg::VALUE_WIDTH-1:0]    csr_write_data
);
   import tmp_pkg::*;

   op_type   op;
   stat_type stat;

   tmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .op        (op)
   );

   tmp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .stat             (stat),
      .req_action       (req_action),
      .req_time_step    (req_time_step),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_velocity     (rsp_velocity),
      .rsp_moving       (rsp_moving),
      .rsp_phase        (rsp_phase),
      .rsp_status       (rsp_status)
   );

   // an accepted transaction holds off the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a transaction is in work");

   // a moving result always carries a non-idle phase
   a_phase_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_moving == (rsp_phase != PH_IDLE)))
      else $error("phase disagrees with moving flag");

   // a rejected start leaves the profile stopped
   a_reject_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_moving)
      else $error("rejected start reports motion");

endmodule

`default_nettype wire

FILE: hdl/tmp_ctrl.sv
// ----------------------------------------------------------------------------
// Trapezoid motion profile controller
// Sequences the datapath: handshake, planning with shared divider and
// square root steps, tick updates and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tmp_pkg::stat_type stat,
   output tmp_pkg::op_type       op
);
   import tmp_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DISPATCH = 4'd1;
   localparam logic [3:0] ST_SQ       = 4'd2;
   localparam logic [3:0] ST_DIVI     = 4'd3;
   localparam logic [3:0] ST_DIVR     = 4'd4;
   localparam logic [3:0] ST_DIVS     = 4'd5;
   localparam logic [3:0] ST_PLAN     = 4'd6;
   localparam logic [3:0] ST_SH       = 4'd7;
   localparam logic [3:0] ST_SQI      = 4'd8;
   localparam logic [3:0] ST_SQR      = 4'd9;
   localparam logic [3:0] ST_PEAK     = 4'd10;
   localparam logic [3:0] ST_T1       = 4'd11;
   localparam logic [3:0] ST_T2       = 4'd12;
   localparam logic [3:0] ST_T3       = 4'd13;
   localparam logic [3:0] ST_CRU      = 4'd14;
   localparam logic [3:0] ST_EMIT     = 4'd15;

   localparam logic [1:0] DST_UP = 2'd0;
   localparam logic [1:0] DST_DN = 2'd1;
   localparam logic [1:0] DST_H  = 2'd2;

   localparam logic [5:0] DIV_LAST  = 6'd63;
   localparam logic [5:0] SQRT_LAST = 6'd31;

   logic [3:0] state_ff, state_in;
   logic [1:0] dst_ff, dst_in;
   logic       replan_ff, replan_in;
   logic       dec_ff, dec_in;
   logic [5:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   // next state and command
   always_comb begin
      state_in  = state_ff;
      dst_in    = dst_ff;
      replan_in = replan_ff;
      dec_in    = dec_ff;
      cnt_in    = cnt_ff;
      op        = OP_NOP;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op       = OP_CAPTURE;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (stat.act) begin
               if (stat.lim_bad) begin
                  op       = OP_REJECT;
                  state_in = ST_EMIT;
               end else begin
                  op        = OP_CHECK;
                  dst_in    = DST_UP;
                  replan_in = 1'b0;
                  state_in  = ST_SQ;
               end
            end else begin
               priority if (stat.tick_skip) begin
                  state_in = ST_EMIT;
               end else if (stat.tick_finish) begin
                  op       = OP_FINISH;
                  state_in = ST_EMIT;
               end else if (stat.in_accel) begin
                  op       = OP_MUL_VDT;
                  dec_in   = 1'b0;
                  state_in = ST_T1;
               end else if (stat.in_decel) begin
                  op       = OP_MUL_VDT;
                  dec_in   = 1'b1;
                  state_in = ST_T1;
               end else begin
                  op       = OP_MUL_PDT;
                  state_in = ST_CRU;
               end
            end
         end
         ST_SQ: begin
            op       = OP_SQ;
            state_in = ST_DIVI;
         end
         ST_DIVI: begin
            unique case (dst_ff)
               DST_UP:  op = OP_DIVINIT_UP;
               DST_DN:  op = OP_DIVINIT_DN;
               default: op = OP_DIVINIT_H;
            endcase
            cnt_in   = '0;
            state_in = ST_DIVR;
         end
         ST_DIVR: begin
            op     = OP_DIV_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_DIVS;
            end
         end
         ST_DIVS: begin
            unique case (dst_ff)
               DST_UP: begin
                  op       = OP_STORE_UP;
                  dst_in   = DST_DN;
                  state_in = ST_SQ;
               end
               DST_DN: begin
                  op       = OP_STORE_DN;
                  state_in = ST_PLAN;
               end
               default: begin
                  op       = OP_STORE_H;
                  state_in = ST_SH;
               end
            endcase
         end
         ST_PLAN: begin
            if (stat.too_long && !replan_ff) begin
               op       = OP_AD;
               dst_in   = DST_H;
               state_in = ST_DIVI;
            end else begin
               op       = OP_BEGIN;
               state_in = ST_EMIT;
            end
         end
         ST_SH: begin
            op       = OP_SH;
            state_in = ST_SQI;
         end
         ST_SQI: begin
            op       = OP_SQRT_INIT;
            cnt_in   = '0;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            op     = OP_SQRT_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = ST_PEAK;
            end
         end
         ST_PEAK: begin
            op        = OP_PEAK;
            replan_in = 1'b1;
            dst_in    = DST_UP;
            state_in  = ST_SQ;
         end
         ST_T1: begin
            op       = dec_ff ? OP_MUL_DDT : OP_MUL_ADT;
            state_in = ST_T2;
         end
         ST_T2: begin
            op       = OP_MUL_LOSS;
            state_in = ST_T3;
         end
         ST_T3: begin
            op       = dec_ff ? OP_DECEL_UPD : OP_ACCEL_UPD;
            state_in = ST_EMIT;
         end
         ST_CRU: begin
            op       = OP_CRUISE_UPD;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               op       = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         dst_ff    <= DST_UP;
         replan_ff <= 1'b0;
         dec_ff    <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         dst_ff    <= dst_in;
         replan_ff <= replan_in;
         dec_ff    <= dec_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/tmp_dp.sv
// ----------------------------------------------------------------------------
// Trapezoid motion profile datapath
// Limit registers, profile state, one shared multiplier, a bit-serial
// divider, a bit-pair square root unit and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmp_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire tmp_pkg::op_type                    op,
   output tmp_pkg::stat_type                       stat,
   input  wire logic                               req_action,
   input  wire logic [tmp_pkg::DT_WIDTH-1:0]       req_time_step,
   input  wire logic                               csr_write_enable,
   input  wire logic [tmp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tmp_pkg::VALUE_WIDTH-1:0]    csr_write_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [tmp_pkg::VALUE_WIDTH-1:0]         rsp_position,
   output logic [tmp_pkg::VALUE_WIDTH-1:0]         rsp_velocity,
   output logic                                    rsp_moving,
   output logic [1:0]                              rsp_phase,
   output logic                                    rsp_status
);
   import tmp_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int PW = PROD_WIDTH;

   // saturate a wide unsigned sum to the value range
   function automatic logic [W-1:0] sat_value(input logic [W+1:0] x);
      logic [W-1:0] r;
      r = (x[W+1:W] != 2'd0) ? {W{1'b1}} : x[W-1:0];
      return r;
   endfunction

   logic [W-1:0]  accel_ff, decel_ff, vlim_ff, target_ff;
   logic [W-1:0]  pos_ff, pos_in, vel_ff, vel_in, peak_ff, peak_in;
   logic [W-1:0]  rup_ff, rup_in, rdn_ff, rdn_in;
   logic          active_ff, active_in, status_ff, status_in;
   logic          act_ff, act_in;
   logic [DT_WIDTH-1:0] dt_ff, dt_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [PW-1:0] quo_ff, quo_in;
   logic [W:0]    rem_ff, rem_in, den_ff, den_in;
   logic [W-1:0]  h_ff, h_in, gain_ff, gain_in, dv_ff, dv_in;
   logic [PW-1:0] x_ff, x_in, root_ff, root_in, bit_ff, bit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  rsp_pos_ff, rsp_vel_ff;
   logic          rsp_moving_ff, rsp_status_ff;
   logic [1:0]    rsp_phase_ff, phase_now;

   logic [W-1:0]  mul_a, mul_b;
   logic [PW-1:0] mul_p;
   logic [W+1:0]  div_r2;
   logic          div_ge;
   logic [PW:0]   q_round;
   logic [W-1:0]  q_sat;
   logic [PW-1:0] sq_t;
   logic [W-1:0]  dstart, loss, dv_now, root_lo, peak_c;
   logic [W:0]    nv_up;
   logic [W-1:0]  nv_dn;

   assign mul_p = mul_a * mul_b;
   assign dv_now = prod_ff[DT_FRAC_BITS +: W];
   assign loss   = prod_ff[DT_FRAC_BITS+1 +: W];

   // restoring division step
   assign div_r2 = {rem_ff, quo_ff[PW-1]};
   assign div_ge = div_r2 >= {1'b0, den_ff};

   // round the quotient up and saturate
   assign q_round = {1'b0, quo_ff} + {{PW{1'b0}}, (rem_ff != '0)};
   assign q_sat   = (q_round[PW:W] != '0) ? {W{1'b1}} : q_round[W-1:0];

   // square root trial value and clamped peak
   assign sq_t    = root_ff + bit_ff;
   assign root_lo = (root_ff > {{W{1'b0}}, vlim_ff}) ? vlim_ff : root_ff[W-1:0];
   assign peak_c  = (root_lo == '0) ? {{(W-1){1'b0}}, 1'b1} : root_lo;

   assign nv_up = {1'b0, vel_ff} + {1'b0, dv_ff};
   assign nv_dn = (vel_ff > dv_ff) ? (vel_ff - dv_ff) : '0;

   // phase of the profile from the current state
   assign dstart = (target_ff > rdn_ff) ? (target_ff - rdn_ff) : '0;
   always_comb begin
      priority if (!active_ff) begin
         phase_now = PH_IDLE;
      end else if (pos_ff < rup_ff) begin
         phase_now = PH_ACCEL;
      end else if (pos_ff >= dstart) begin
         phase_now = PH_DECEL;
      end else begin
         phase_now = PH_CRUISE;
      end
   end

   // status toward the controller
   always_comb begin
      stat.act         = act_ff;
      stat.lim_bad     = (accel_ff == '0) || (decel_ff == '0) ||
                         (vlim_ff == '0) || (target_ff == '0);
      stat.tick_skip   = !active_ff || (dt_ff == '0);
      stat.tick_finish = (pos_ff >= target_ff) && (vel_ff == '0);
      stat.in_accel    = pos_ff < rup_ff;
      stat.in_decel    = pos_ff >= dstart;
      stat.too_long    = ({1'b0, rup_ff} + {1'b0, rdn_ff}) > {1'b0, target_ff};
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // execute the command
   always_comb begin
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      peak_in      = peak_ff;
      rup_in       = rup_ff;
      rdn_in       = rdn_ff;
      active_in    = active_ff;
      status_in    = status_ff;
      act_in       = act_ff;
      dt_in        = dt_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      h_in         = h_ff;
      gain_in      = gain_ff;
      dv_in        = dv_ff;
      x_in         = x_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a        = '0;
      mul_b        = '0;
      unique case (op)
         OP_CAPTURE: begin
            act_in    = req_action;
            dt_in     = req_time_step;
            status_in = 1'b0;
         end
         OP_REJECT: begin
            active_in = 1'b0;
            status_in = 1'b1;
         end
         OP_CHECK: peak_in = vlim_ff;
         OP_SQ: begin
            mul_a   = peak_ff;
            mul_b   = peak_ff;
            prod_in = mul_p;
         end
         OP_DIVINIT_UP, OP_DIVINIT_DN, OP_DIVINIT_H: begin
            quo_in = prod_ff;
            rem_in = '0;
            unique case (op)
               OP_DIVINIT_UP: den_in = {accel_ff, 1'b0};
               OP_DIVINIT_DN: den_in = {decel_ff, 1'b0};
               default:       den_in = {1'b0, accel_ff} + {1'b0, decel_ff};
            endcase
         end
         OP_DIV_STEP: begin
            quo_in = {quo_ff[PW-2:0], div_ge};
            rem_in = div_ge ? (W+1)'(div_r2 - {1'b0, den_ff}) : div_r2[W:0];
         end
         OP_STORE_UP: rup_in = q_sat;
         OP_STORE_DN: rdn_in = q_sat;
         OP_STORE_H:  h_in   = quo_ff[W-1:0];
         OP_AD: begin
            mul_a   = accel_ff;
            mul_b   = decel_ff;
            prod_in = mul_p;
         end
         OP_SH: begin
            mul_a   = target_ff;
            mul_b   = h_ff;
            prod_in = mul_p;
         end
         OP_SQRT_INIT: begin
            x_in    = prod_ff[PW-1] ? {PW{1'b1}} : {prod_ff[PW-2:0], 1'b0};
            root_in = '0;
            bit_in  = {2'b01, {(PW-2){1'b0}}};
         end
         OP_SQRT_STEP: begin
            if (x_ff >= sq_t) begin
               x_in    = x_ff - sq_t;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         OP_PEAK: peak_in = peak_c;
         OP_BEGIN: begin
            pos_in    = '0;
            vel_in    = '0;
            active_in = 1'b1;
         end
         OP_FINISH: begin
            pos_in    = target_ff;
            vel_in    = '0;
            active_in = 1'b0;
         end
         OP_MUL_VDT: begin
            mul_a   = vel_ff;
            mul_b   = {{(W-DT_WIDTH){1'b0}}, dt_ff};
            prod_in = mul_p;
         end
         OP_MUL_ADT, OP_MUL_DDT: begin
            gain_in = prod_ff[DT_FRAC_BITS +: W];
            mul_a   = (op == OP_MUL_ADT) ? accel_ff : decel_ff;
            mul_b   = {{(W-DT_WIDTH){1'b0}}, dt_ff};
            prod_in = mul_p;
         end
         OP_MUL_PDT: begin
            mul_a   = peak_ff;
            mul_b   = {{(W-DT_WIDTH){1'b0}}, dt_ff};
            prod_in = mul_p;
         end
         OP_MUL_LOSS: begin
            dv_in   = dv_now;
            mul_a   = dv_now;
            mul_b   = {{(W-DT_WIDTH){1'b0}}, dt_ff};
            prod_in = mul_p;
         end
         OP_ACCEL_UPD: begin
            pos_in = sat_value({2'b00, pos_ff} + {2'b00, gain_ff} + {2'b00, loss});
            vel_in = (nv_up > {1'b0, peak_ff}) ? peak_ff : nv_up[W-1:0];
         end
         OP_DECEL_UPD: begin
            if (nv_dn == '0) begin
               pos_in    = target_ff;
               vel_in    = '0;
               active_in = 1'b0;
            end else begin
               vel_in = nv_dn;
               if (gain_ff > loss) begin
                  pos_in = sat_value({2'b00, pos_ff} + {2'b00, gain_ff - loss});
               end
            end
         end
         OP_CRUISE_UPD: begin
            vel_in = peak_ff;
            pos_in = sat_value({2'b00, pos_ff} + {2'b00, prod_ff[DT_FRAC_BITS +: W]});
         end
         OP_EMIT: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff  <= '0;
         decel_ff  <= '0;
         vlim_ff   <= '0;
         target_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_ACCEL:  accel_ff  <= csr_write_data;
            REG_DECEL:  decel_ff  <= csr_write_data;
            REG_VLIM:   vlim_ff   <= csr_write_data;
            default:    target_ff <= csr_write_data;
         endcase
      end
   end

   // profile state and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         vel_ff       <= '0;
         peak_ff      <= '0;
         rup_ff       <= '0;
         rdn_ff       <= '0;
         active_ff    <= 1'b0;
         status_ff    <= 1'b0;
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         peak_ff      <= peak_in;
         rup_ff       <= rup_in;
         rdn_ff       <= rdn_in;
         active_ff    <= active_in;
         status_ff    <= status_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      dt_ff   <= dt_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      h_ff    <= h_in;
      gain_ff <= gain_in;
      dv_ff   <= dv_in;
      x_ff    <= x_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   // result payload
   always_ff @(posedge clock) begin
      if (op == OP_EMIT) begin
         rsp_pos_ff    <= pos_ff;
         rsp_vel_ff    <= vel_ff;
         rsp_moving_ff <= active_ff;
         rsp_phase_ff  <= phase_now;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_velocity = rsp_vel_ff;
   assign rsp_moving   = rsp_moving_ff;
   assign rsp_phase    = rsp_phase_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

`default_nettype wire
